// File: src/sfrv_pkg.sv
// Shared types and constants of the sensor frame receiver and validator.
// Holds the frame geometry, register map, result codes and config/result structs.
// No dependencies.
package sfrv_pkg;

  // Frame geometry
  localparam int FRAME_LENGTH = 10;
  localparam int IDX_W        = 4;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LENGTH - 1);

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int FIELD_W = 16;
  localparam int OFF_W   = 3;
  localparam int STAT_W  = 2;

  // Configuration port widths
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER_FIRST  = 4'd0,
    REG_HEADER_SECOND = 4'd1,
    REG_HEADER_THIRD  = 4'd2,
    REG_FIELD_OFFSET  = 4'd3,
    REG_FIRST_MIN     = 4'd4,
    REG_FIRST_MAX     = 4'd5,
    REG_SECOND_MIN    = 4'd6,
    REG_SECOND_MAX    = 4'd7
  } cfg_reg_e;

  // Reset values of the registers
  localparam logic [BYTE_W-1:0]  RST_HEADER_FIRST  = 8'd35;   // '#'
  localparam logic [BYTE_W-1:0]  RST_HEADER_SECOND = 8'd38;   // '&'
  localparam logic [BYTE_W-1:0]  RST_HEADER_THIRD  = 8'd114;  // 'r'
  localparam logic [OFF_W-1:0]   RST_FIELD_OFFSET  = 3'd3;
  localparam logic [FIELD_W-1:0] RST_FIRST_MIN     = 16'd240;
  localparam logic [FIELD_W-1:0] RST_FIRST_MAX     = 16'd300;
  localparam logic [FIELD_W-1:0] RST_SECOND_MIN    = 16'd10;
  localparam logic [FIELD_W-1:0] RST_SECOND_MAX    = 16'd4000;

  // Result codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_CSUM  = 2'd2
  } status_e;

  typedef struct packed {
    logic [BYTE_W-1:0]  header_first;
    logic [BYTE_W-1:0]  header_second;
    logic [BYTE_W-1:0]  header_third;
    logic [OFF_W-1:0]   field_offset;
    logic [FIELD_W-1:0] first_min;
    logic [FIELD_W-1:0] first_max;
    logic [FIELD_W-1:0] second_min;
    logic [FIELD_W-1:0] second_max;
  } cfg_t;

  typedef struct packed {
    status_e            status;
    logic [FIELD_W-1:0] first_value;
    logic [FIELD_W-1:0] second_value;
  } result_t;

endpackage

// File: src/sfrv_if.sv
// Channel interfaces of the sensor frame receiver: byte input, result output
// and configuration write. Valid/ready handshake on each.
// Depends on sfrv_pkg.
interface sfrv_byte_if;
  logic                       valid;
  logic                       ready;
  logic [sfrv_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfrv_result_if;
  logic                        valid;
  logic                        ready;
  logic [sfrv_pkg::STAT_W-1:0]  status;
  logic [sfrv_pkg::FIELD_W-1:0] first_value;
  logic [sfrv_pkg::FIELD_W-1:0] second_value;

  modport source (output valid, output status, output first_value, output second_value,
                  input ready);
  modport sink   (input valid, input status, input first_value, input second_value,
                  output ready);
endinterface

interface sfrv_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sfrv_pkg::CFG_IDX_W-1:0]  index;
  logic [sfrv_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/sensor_frame_receiver_validator_core.sv
// Datapath: a byte taken into the input register is evaluated from it, and its result,
//   if any, is registered in the output register when the byte advances.
// Throughput: one byte per cycle while results drain; a result held in the output
//   register stalls the byte in the input register, so the input takes one more byte.
// Reset (synchronous, rst high): registers take their defaults, the hunt returns to
//   byte 0 and both channel registers empty. No clearing pass.
// Depends on sfrv_pkg, sfrv_if, sfrv_cfg_regs and sfrv_frame_tracker.
module sensor_frame_receiver_validator_core (
  input  logic            clk,
  input  logic            rst,
  sfrv_byte_if.sink       rx,
  sfrv_result_if.source   res,
  sfrv_cfg_if.sink        cfg
);
  import sfrv_pkg::*;

  cfg_t              regs;
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              advance;
  logic              trk_valid;
  result_t           trk_res;
  logic              out_valid;
  result_t           out_data;

  sfrv_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  sfrv_frame_tracker u_tracker (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .rx_byte   (in_byte),
    .regs      (regs),
    .res_valid (trk_valid),
    .res       (trk_res)
  );

  // Move the held byte on when the output slot is free or draining
  assign advance  = in_valid && (!out_valid || res.ready);
  assign rx.ready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= trk_valid;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && trk_valid) begin
      out_data <= trk_res;
    end
  end

  assign res.valid        = out_valid;
  assign res.status       = out_data.status;
  assign res.first_value  = out_data.first_value;
  assign res.second_value = out_data.second_value;

endmodule

// File: src/sfrv_cfg_regs.sv
// Configuration register file of the sensor frame receiver.
// Takes write requests from the config channel and presents them as a cfg_t.
// Depends on sfrv_pkg and sfrv_cfg_if.
module sfrv_cfg_regs (
  input  logic            clk,
  input  logic            rst,
  sfrv_cfg_if.sink        cfg,
  output sfrv_pkg::cfg_t  regs
);
  import sfrv_pkg::*;

  // Always take write requests
  assign cfg.ready = 1'b1;

  // Write the addressed register; drop requests beyond the map
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.header_first  <= RST_HEADER_FIRST;
      regs.header_second <= RST_HEADER_SECOND;
      regs.header_third  <= RST_HEADER_THIRD;
      regs.field_offset  <= RST_FIELD_OFFSET;
      regs.first_min     <= RST_FIRST_MIN;
      regs.first_max     <= RST_FIRST_MAX;
      regs.second_min    <= RST_SECOND_MIN;
      regs.second_max    <= RST_SECOND_MAX;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_HEADER_FIRST:  regs.header_first  <= cfg.data[BYTE_W-1:0];
        REG_HEADER_SECOND: regs.header_second <= cfg.data[BYTE_W-1:0];
        REG_HEADER_THIRD:  regs.header_third  <= cfg.data[BYTE_W-1:0];
        REG_FIELD_OFFSET:  regs.field_offset  <= cfg.data[OFF_W-1:0];
        REG_FIRST_MIN:     regs.first_min     <= cfg.data[FIELD_W-1:0];
        REG_FIRST_MAX:     regs.first_max     <= cfg.data[FIELD_W-1:0];
        REG_SECOND_MIN:    regs.second_min    <= cfg.data[FIELD_W-1:0];
        REG_SECOND_MAX:    regs.second_max    <= cfg.data[FIELD_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: src/sfrv_frame_tracker.sv
// Frame hunt state and per-byte evaluation of the sensor frame receiver.
// Holds byte index, running sum and captured fields; flags a result at frame end.
// Depends on sfrv_pkg.
module sfrv_frame_tracker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [sfrv_pkg::BYTE_W-1:0] rx_byte,
  input  sfrv_pkg::cfg_t             regs,
  output logic                       res_valid,
  output sfrv_pkg::result_t          res
);
  import sfrv_pkg::*;

  logic [IDX_W-1:0]   byte_index;
  logic [IDX_W-1:0]   byte_index_next;
  logic [BYTE_W-1:0]  running_sum;
  logic [BYTE_W-1:0]  running_sum_next;
  logic [FIELD_W-1:0] first_field;
  logic [FIELD_W-1:0] first_field_next;
  logic [FIELD_W-1:0] second_field;
  logic [FIELD_W-1:0] second_field_next;

  logic [IDX_W-1:0]   off;
  logic               wait_first;
  logic               restart;
  logic               last;
  logic               cap_first;
  logic               cap_second;
  logic [FIELD_W-1:0] first_upd;
  logic [FIELD_W-1:0] second_upd;
  logic               in_range;

  // Header checks and field positions
  assign off        = {1'b0, regs.field_offset};
  assign wait_first = (byte_index == '0) && (rx_byte != regs.header_first);
  assign restart    = ((byte_index == IDX_W'(1)) && (rx_byte != regs.header_second)) ||
                      ((byte_index == IDX_W'(2)) && (rx_byte != regs.header_third));
  assign last       = (byte_index >= LAST_IDX);
  assign cap_first  = (byte_index == off) || (byte_index == off + IDX_W'(1));
  assign cap_second = (byte_index == off + IDX_W'(2)) || (byte_index == off + IDX_W'(3));

  // Shift the byte into the captured fields
  assign first_upd  = cap_first  ? {first_field[BYTE_W-1:0], rx_byte}  : first_field;
  assign second_upd = cap_second ? {second_field[BYTE_W-1:0], rx_byte} : second_field;

  assign in_range = (first_upd >= regs.first_min) && (first_upd <= regs.first_max) &&
                    (second_upd >= regs.second_min) && (second_upd <= regs.second_max);

  // Build the result at the checksum byte
  always_comb begin
    res_valid = !wait_first && !restart && last;
    if (running_sum != rx_byte) begin
      res.status       = STAT_CSUM;
      res.first_value  = '0;
      res.second_value = '0;
    end else begin
      res.status       = in_range ? STAT_OK : STAT_RANGE;
      res.first_value  = first_upd;
      res.second_value = second_upd;
    end
  end

  // Advance, hold or restart the hunt
  always_comb begin
    byte_index_next   = byte_index;
    running_sum_next  = running_sum;
    first_field_next  = first_field;
    second_field_next = second_field;
    if (wait_first) begin
      byte_index_next = byte_index;
    end else if (restart || last) begin
      byte_index_next   = '0;
      running_sum_next  = '0;
      first_field_next  = '0;
      second_field_next = '0;
    end else begin
      byte_index_next   = byte_index + IDX_W'(1);
      running_sum_next  = running_sum + rx_byte;
      first_field_next  = first_upd;
      second_field_next = second_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index   <= '0;
      running_sum  <= '0;
      first_field  <= '0;
      second_field <= '0;
    end else if (step) begin
      byte_index   <= byte_index_next;
      running_sum  <= running_sum_next;
      first_field  <= first_field_next;
      second_field <= second_field_next;
    end
  end

`ifndef SYNTHESIS
  a_index_in_frame: assert property (@(posedge clk) disable iff (rst)
    byte_index <= LAST_IDX)
    else $error("byte index beyond frame end");

  a_restart_after_result: assert property (@(posedge clk) disable iff (rst)
    step && res_valid |=> (byte_index == '0) && (running_sum == '0))
    else $error("hunt not restarted after a result");

  a_index_steps_by_one: assert property (@(posedge clk) disable iff (rst)
    step |=> (byte_index == '0) || (byte_index == $past(byte_index) + IDX_W'(1)) ||
             (byte_index == $past(byte_index)))
    else $error("byte index jumped");

  a_hold_without_step: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(byte_index) && $stable(running_sum))
    else $error("hunt state moved without a byte");
`endif

endmodule
